/* design/xsp_pkg.sv */
package xsp_pkg;

	localparam int unsigned OBJECT_BITS_DEF = 23;
	localparam int unsigned OFF_W = 34;
	localparam int unsigned GEN_W = 16;

	localparam logic [OFF_W-1:0] OFF_MAX = 34'd9999999999;
	localparam logic [GEN_W-1:0] GEN_MAX = 16'hFFFF;

	// result kinds
	localparam logic [1:0] KIND_ENTRY = 2'd0;
	localparam logic [1:0] KIND_OK    = 2'd1;
	localparam logic [1:0] KIND_FAIL  = 2'd2;

	// parser modes
	localparam logic [3:0] M_SEARCH   = 4'd0;
	localparam logic [3:0] M_LEAD     = 4'd1;
	localparam logic [3:0] M_HEAD     = 4'd2;
	localparam logic [3:0] M_START    = 4'd3;
	localparam logic [3:0] M_GAP1     = 4'd4;
	localparam logic [3:0] M_COUNT    = 4'd5;
	localparam logic [3:0] M_GAP2     = 4'd6;
	localparam logic [3:0] M_OFF_LEAD = 4'd7;
	localparam logic [3:0] M_OFF      = 4'd8;
	localparam logic [3:0] M_GEN      = 4'd9;
	localparam logic [3:0] M_TYPE     = 4'd10;
	localparam logic [3:0] M_TAIL     = 4'd11;
	localparam logic [3:0] M_DONE     = 4'd12;

	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_T    = 8'h74;
	localparam logic [7:0] CH_N    = 8'h6E;
	localparam logic [7:0] CH_X    = 8'h78;

	localparam logic [7:0] KW_TEXT [4] = '{8'h78, 8'h72, 8'h65, 8'h66};

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} in_word_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic       in_use;
	} res_meta_t;

endpackage

/* design/xsp_in_if.sv */
interface xsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       last_byte;

	modport source (output valid, output byte_in, output last_byte, input ready);
	modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

/* design/xsp_out_if.sv */
interface xsp_out_if import xsp_pkg::*; #(
	parameter int unsigned OBJ_W = OBJECT_BITS_DEF
);
	logic             valid;
	logic             ready;
	logic [1:0]       kind;
	logic [OBJ_W-1:0] object_number;
	logic [OFF_W-1:0] byte_offset;
	logic [GEN_W-1:0] generation;
	logic             in_use;

	modport source (output valid, output kind, output object_number, output byte_offset,
		output generation, output in_use, input ready);
	modport sink (input valid, input kind, input object_number, input byte_offset,
		input generation, input in_use, output ready);
endinterface

/* design/xsp_in_stage.sv */
module xsp_in_stage import xsp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	xsp_in_if.sink    stream,
	input  logic      fire,
	output logic      valid_s1,
	output in_word_t  word_s1
);

	assign stream.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			word_s1.data <= stream.byte_in;
			word_s1.last <= stream.last_byte;
		end
	end

endmodule

/* design/xsp_parse.sv */
module xsp_parse import xsp_pkg::*; #(
	parameter int unsigned OBJECT_BITS = OBJECT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  in_word_t               word_s1,
	output res_meta_t              meta,
	output logic [OBJECT_BITS-1:0] obj,
	output logic [OFF_W-1:0]       off,
	output logic [GEN_W-1:0]       gen
);

	localparam logic [OBJECT_BITS-1:0] OBJ_MAX = '1;

	logic [3:0]             mode_q, mode_nxt, m;
	logic [1:0]             kw_q, kw_nxt;
	logic [OBJECT_BITS-1:0] start_q, start_nxt;
	logic [OBJECT_BITS-1:0] left_q, left_nxt;
	logic [OBJECT_BITS-1:0] idx_q, idx_nxt;
	logic [OFF_W-1:0]       off_q, off_nxt;
	logic [GEN_W-1:0]       gen_q, gen_nxt;
	logic [OBJECT_BITS-1:0] high_q, high_nxt;
	logic                   seen_q, seen_nxt;

	logic [7:0]             b;
	logic [3:0]             d;
	logic                   dig, gap, lead, ws;
	logic                   status_done;
	logic [OBJECT_BITS:0]   sum;
	logic [OBJECT_BITS-1:0] obj_sat;

	function automatic logic [OBJECT_BITS-1:0] acc_obj(input logic [OBJECT_BITS-1:0] a,
		input logic [3:0] dd);
		logic [OBJECT_BITS+3:0] v;
		v = ({4'b0, a} << 3) + ({4'b0, a} << 1) + {{OBJECT_BITS{1'b0}}, dd};
		return (v > {4'b0, OBJ_MAX}) ? OBJ_MAX : v[OBJECT_BITS-1:0];
	endfunction

	function automatic logic [OFF_W-1:0] acc_off(input logic [OFF_W-1:0] a,
		input logic [3:0] dd);
		logic [OFF_W+3:0] v;
		v = ({4'b0, a} << 3) + ({4'b0, a} << 1) + {{OFF_W{1'b0}}, dd};
		return (v > {4'b0, OFF_MAX}) ? OFF_MAX : v[OFF_W-1:0];
	endfunction

	function automatic logic [GEN_W-1:0] acc_gen(input logic [GEN_W-1:0] a,
		input logic [3:0] dd);
		logic [GEN_W+3:0] v;
		v = ({4'b0, a} << 3) + ({4'b0, a} << 1) + {{GEN_W{1'b0}}, dd};
		return (v > {4'b0, GEN_MAX}) ? GEN_MAX : v[GEN_W-1:0];
	endfunction

	assign b    = word_s1.data;
	assign d    = 4'(b - CH_0);
	assign dig  = (b >= CH_0) && (b <= CH_9);
	assign gap  = (b == CH_SP) || (b == CH_LF);
	assign lead = gap || (b == CH_CR);
	assign ws   = (b == CH_SP) || ((b >= CH_TAB) && (b <= CH_CR));

	assign sum     = {1'b0, start_q} + {1'b0, idx_q};
	assign obj_sat = sum[OBJECT_BITS] ? OBJ_MAX : sum[OBJECT_BITS-1:0];

	always_comb begin
		mode_nxt    = mode_q;
		kw_nxt      = kw_q;
		start_nxt   = start_q;
		left_nxt    = left_q;
		idx_nxt     = idx_q;
		off_nxt     = off_q;
		gen_nxt     = gen_q;
		high_nxt    = high_q;
		seen_nxt    = seen_q;
		meta        = '{valid: 1'b0, kind: KIND_ENTRY, in_use: 1'b0};
		obj         = '0;
		off         = '0;
		gen         = '0;
		status_done = 1'b0;
		m           = mode_q;

		if (mode_q != M_DONE) begin
			// modes that hand the same byte on to the next mode
			if (m == M_LEAD && !lead) m = M_HEAD;
			if (m == M_START && !dig) m = M_GAP1;
			if (m == M_GAP1 && !gap) m = M_COUNT;
			if (m == M_COUNT && !dig) m = M_GAP2;
			if (m == M_GAP2 && !gap) begin
				m = (left_q == '0) ? M_HEAD : M_OFF_LEAD;
				off_nxt = '0;
				gen_nxt = '0;
			end
			mode_nxt = m;

			unique case (m) inside
				M_SEARCH: begin
					if (b == KW_TEXT[kw_q]) begin
						if (kw_q == 2'd3) begin
							kw_nxt   = 2'd0;
							mode_nxt = M_LEAD;
						end else begin
							kw_nxt = kw_q + 2'd1;
						end
					end else begin
						kw_nxt = (b == CH_X) ? 2'd1 : 2'd0;
					end
				end
				M_LEAD, M_GAP1, M_GAP2: ;
				M_HEAD: begin
					if (b == CH_T) begin
						meta        = '{valid: 1'b1, kind: seen_q ? KIND_OK : KIND_FAIL,
							in_use: 1'b0};
						obj         = high_q;
						status_done = 1'b1;
						mode_nxt    = M_DONE;
					end else if (dig) begin
						start_nxt = acc_obj('0, d);
						left_nxt  = '0;
						idx_nxt   = '0;
						mode_nxt  = M_START;
					end
				end
				M_START: start_nxt = acc_obj(start_q, d);
				M_COUNT: left_nxt = acc_obj(left_q, d);
				M_OFF_LEAD: begin
					if (dig) begin
						off_nxt  = acc_off('0, d);
						mode_nxt = M_OFF;
					end else if (!ws) begin
						mode_nxt = M_GEN;
					end
				end
				M_OFF: begin
					if (dig) off_nxt = acc_off(off_q, d);
					else mode_nxt = M_GEN;
				end
				M_GEN: begin
					if (dig) gen_nxt = acc_gen(gen_q, d);
					else mode_nxt = M_TYPE;
				end
				M_TYPE: begin
					if (obj_sat > high_q) high_nxt = obj_sat;
					seen_nxt = 1'b1;
					meta     = '{valid: 1'b1, kind: KIND_ENTRY, in_use: (b == CH_N)};
					obj      = obj_sat;
					off      = off_q;
					gen      = gen_q;
					if (idx_q != OBJ_MAX) idx_nxt = idx_q + OBJECT_BITS'(1);
					if (left_q != '0) left_nxt = left_q - OBJECT_BITS'(1);
					mode_nxt = M_TAIL;
				end
				M_TAIL: begin
					off_nxt  = '0;
					gen_nxt  = '0;
					mode_nxt = (left_q == '0) ? M_HEAD : M_OFF_LEAD;
				end
				default: mode_nxt = M_DONE;
			endcase

			if (word_s1.last && !status_done) begin
				meta = '{valid: 1'b1,
					kind: ((mode_nxt != M_SEARCH) && seen_nxt) ? KIND_OK : KIND_FAIL,
					in_use: 1'b0};
				obj  = high_nxt;
				off  = '0;
				gen  = '0;
			end
		end

		// end of document: back to keyword search, totals kept
		if (word_s1.last) begin
			mode_nxt  = M_SEARCH;
			kw_nxt    = 2'd0;
			start_nxt = '0;
			left_nxt  = '0;
			idx_nxt   = '0;
			off_nxt   = '0;
			gen_nxt   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_SEARCH;
			kw_q    <= 2'd0;
			start_q <= '0;
			left_q  <= '0;
			idx_q   <= '0;
			off_q   <= '0;
			gen_q   <= '0;
			high_q  <= '0;
			seen_q  <= 1'b0;
		end else if (fire) begin
			mode_q  <= mode_nxt;
			kw_q    <= kw_nxt;
			start_q <= start_nxt;
			left_q  <= left_nxt;
			idx_q   <= idx_nxt;
			off_q   <= off_nxt;
			gen_q   <= gen_nxt;
			high_q  <= high_nxt;
			seen_q  <= seen_nxt;
		end
	end

endmodule

/* design/xsp_out_stage.sv */
module xsp_out_stage import xsp_pkg::*; #(
	parameter int unsigned OBJECT_BITS = OBJECT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  res_meta_t              meta,
	input  logic [OBJECT_BITS-1:0] obj,
	input  logic [OFF_W-1:0]       off,
	input  logic [GEN_W-1:0]       gen,
	output logic                   free,
	xsp_out_if.source              result
);

	logic load;

	assign free = !result.valid || result.ready;
	assign load = fire && meta.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid <= 1'b0;
		end else if (load) begin
			result.valid <= 1'b1;
		end else if (result.ready) begin
			result.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result.kind          <= meta.kind;
			result.in_use        <= meta.in_use;
			result.object_number <= obj;
			result.byte_offset   <= off;
			result.generation    <= gen;
		end
	end

endmodule

/* design/xref_section_parser_unit.sv */
// channel  | modport | word
// ---------+---------+---------------------------------------------------------
// stream   | sink    | byte_in[7:0], last_byte
// result   | source  | kind[1:0], object_number, byte_offset[33:0],
//          |         | generation[15:0], in_use
//
// One byte per cycle. A byte is registered, parsed in the next cycle against the
// mode registers, and any result is loaded into the output register as the byte
// leaves the input register. A byte with a result waits there only while the
// output register is full and not being taken; the input is held off meanwhile.
// arst_n returns to keyword search and clears the highest object and entry flag.
module xref_section_parser_unit import xsp_pkg::*; #(
	parameter int unsigned OBJECT_BITS = OBJECT_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	xsp_in_if.sink    stream,
	xsp_out_if.source result
);

	logic                   valid_s1;
	in_word_t               word_s1;
	logic                   fire;
	logic                   free;
	res_meta_t              meta;
	logic [OBJECT_BITS-1:0] obj;
	logic [OFF_W-1:0]       off;
	logic [GEN_W-1:0]       gen;

	assign fire = valid_s1 && (!meta.valid || free);

	xsp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream),
		.fire     (fire),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	xsp_parse #(.OBJECT_BITS(OBJECT_BITS)) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.word_s1 (word_s1),
		.meta    (meta),
		.obj     (obj),
		.off     (off),
		.gen     (gen)
	);

	xsp_out_stage #(.OBJECT_BITS(OBJECT_BITS)) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.meta   (meta),
		.obj    (obj),
		.off    (off),
		.gen    (gen),
		.free   (free),
		.result (result)
	);

endmodule

/* tb/sv/xref_section_parser_unit_test.sv */
`timescale 1ns / 100ps

module xref_section_parser_unit_test;
	import xsp_pkg::*;

	localparam int unsigned OBJ_W = OBJECT_BITS_DEF;
	localparam logic [63:0] OBJ_CAP = (64'd1 << OBJ_W) - 64'd1;
	localparam int unsigned PHASE_BYTES = 300;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct {
		logic [1:0]       kind;
		logic [OBJ_W-1:0] obj;
		logic [OFF_W-1:0] off;
		logic [GEN_W-1:0] gen;
		logic             in_use;
	} xref_result_t;

	class xref_tracker;
		logic [3:0]   mode;
		int           kw_count;
		logic [63:0]  sect_start;
		logic [63:0]  left;
		logic [63:0]  idx;
		logic [63:0]  off_acc;
		logic [63:0]  gen_acc;
		logic [63:0]  highest;
		bit           seen;
		xref_result_t pending[$];
		int           errors;

		function new();
			errors = 0;
			highest = 0;
			seen = 0;
			clear_document();
		endfunction

		function void clear_document();
			mode = M_SEARCH;
			kw_count = 0;
			sect_start = 0;
			left = 0;
			idx = 0;
			off_acc = 0;
			gen_acc = 0;
		endfunction

		function bit is_digit(logic [7:0] b);
			return b >= CH_0 && b <= CH_9;
		endfunction

		function bit is_gap(logic [7:0] b);
			return b == CH_SP || b == CH_LF;
		endfunction

		function logic [63:0] times_ten(logic [63:0] acc, logic [7:0] b, logic [63:0] cap);
			logic [63:0] v;
			v = acc * 64'd10 + 64'(b - CH_0);
			return (v > cap) ? cap : v;
		endfunction

		function xref_result_t make_status(bit found);
			xref_result_t r;
			r.kind = (found && seen) ? KIND_OK : KIND_FAIL;
			r.obj = highest[OBJ_W-1:0];
			r.off = '0;
			r.gen = '0;
			r.in_use = 1'b0;
			return r;
		endfunction

		function void take_byte(logic [7:0] b, logic last);
			bit again;
			bit status_sent;
			bit have;
			logic [63:0] obj;
			xref_result_t r;
			status_sent = 0;
			have = 0;
			if (mode == M_DONE) begin
				if (last)
					clear_document();
				return;
			end
			do begin
				again = 0;
				case (mode)
					M_SEARCH: begin
						if (b == KW_TEXT[kw_count]) begin
							kw_count++;
							if (kw_count == 4) begin
								kw_count = 0;
								mode = M_LEAD;
							end
						end else begin
							kw_count = (b == CH_X) ? 1 : 0;
						end
					end
					M_LEAD: begin
						if (!(b == CH_SP || b == CH_LF || b == CH_CR)) begin
							mode = M_HEAD;
							again = 1;
						end
					end
					M_HEAD: begin
						if (b == CH_T) begin
							r = make_status(1);
							have = 1;
							status_sent = 1;
							mode = M_DONE;
						end else if (is_digit(b)) begin
							sect_start = times_ten(0, b, OBJ_CAP);
							left = 0;
							idx = 0;
							mode = M_START;
						end
					end
					M_START: begin
						if (is_digit(b)) begin
							sect_start = times_ten(sect_start, b, OBJ_CAP);
						end else begin
							mode = M_GAP1;
							again = 1;
						end
					end
					M_GAP1: begin
						if (!is_gap(b)) begin
							mode = M_COUNT;
							again = 1;
						end
					end
					M_COUNT: begin
						if (is_digit(b)) begin
							left = times_ten(left, b, OBJ_CAP);
						end else begin
							mode = M_GAP2;
							again = 1;
						end
					end
					M_GAP2: begin
						if (!is_gap(b)) begin
							mode = (left == 0) ? M_HEAD : M_OFF_LEAD;
							off_acc = 0;
							gen_acc = 0;
							again = 1;
						end
					end
					M_OFF_LEAD: begin
						if (is_digit(b)) begin
							off_acc = times_ten(0, b, 64'(OFF_MAX));
							mode = M_OFF;
						end else if (!(b == CH_SP || (b >= CH_TAB && b <= CH_CR))) begin
							mode = M_GEN;
						end
					end
					M_OFF: begin
						if (is_digit(b))
							off_acc = times_ten(off_acc, b, 64'(OFF_MAX));
						else
							mode = M_GEN;
					end
					M_GEN: begin
						if (is_digit(b))
							gen_acc = times_ten(gen_acc, b, 64'(GEN_MAX));
						else
							mode = M_TYPE;
					end
					M_TYPE: begin
						obj = sect_start + idx;
						if (obj > OBJ_CAP)
							obj = OBJ_CAP;
						if (obj > highest)
							highest = obj;
						seen = 1;
						r.kind = KIND_ENTRY;
						r.obj = obj[OBJ_W-1:0];
						r.off = off_acc[OFF_W-1:0];
						r.gen = gen_acc[GEN_W-1:0];
						r.in_use = (b == CH_N);
						have = 1;
						if (idx < OBJ_CAP)
							idx++;
						if (left > 0)
							left--;
						mode = M_TAIL;
					end
					M_TAIL: begin
						off_acc = 0;
						gen_acc = 0;
						mode = (left == 0) ? M_HEAD : M_OFF_LEAD;
					end
					default: mode = M_DONE;
				endcase
			end while (again);
			// on the final byte the status replaces any entry word
			if (last) begin
				if (!status_sent) begin
					r = make_status(mode != M_SEARCH);
					have = 1;
				end
				clear_document();
			end
			if (have)
				pending.push_back(r);
		endfunction

		function void match_result(xref_result_t got);
			xref_result_t want;
			if (pending.size() == 0) begin
				$error("result word with nothing expected: kind %0d object %0d",
					got.kind, got.obj);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind);
				errors++;
			end
			if (got.obj !== want.obj) begin
				$error("object_number: expected %0d, got %0d", want.obj, got.obj);
				errors++;
			end
			if (got.off !== want.off) begin
				$error("byte_offset: expected %0d, got %0d", want.off, got.off);
				errors++;
			end
			if (got.gen !== want.gen) begin
				$error("generation: expected %0d, got %0d", want.gen, got.gen);
				errors++;
			end
			if (got.in_use !== want.in_use) begin
				$error("in_use: expected %0d, got %0d", want.in_use, got.in_use);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	xsp_in_if stream_if();
	xsp_out_if #(.OBJ_W(OBJ_W)) result_if();

	xref_section_parser_unit #(.OBJECT_BITS(OBJ_W)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.result (result_if)
	);

	xref_tracker tracker;
	logic [7:0]  doc_bytes[$];
	int          idle_pct;
	int          stall_pct;
	int          sent_count;
	int          cycle_count;

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	always @(negedge clk)
		result_if.ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		xref_result_t got;
		if (arst_n && result_if.valid && result_if.ready) begin
			got.kind = result_if.kind;
			got.obj = result_if.object_number;
			got.off = result_if.byte_offset;
			got.gen = result_if.generation;
			got.in_use = result_if.in_use;
			tracker.match_result(got);
		end
	end

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			doc_bytes.push_back(s[i]);
	endfunction

	function automatic void add_number(logic [63:0] v, int width);
		string s;
		s = $sformatf("%0d", v);
		while (s.len() < width)
			s = {"0", s};
		add_text(s);
	endfunction

	function automatic void add_random_digits(int n);
		repeat (n)
			doc_bytes.push_back(CH_0 + 8'($urandom_range(9)));
	endfunction

	function automatic void add_noise(int lo, int hi);
		repeat ($urandom_range(hi, lo))
			doc_bytes.push_back(8'($urandom_range(255)));
	endfunction

	// one document, mostly well formed, with random content and the odd defect
	function automatic void build_document();
		string lead_set;
		string ws_set;
		int r;
		int cnt;
		bit cut;
		lead_set = " \n\r";
		ws_set = "\t\v\f \r\n";
		cut = 0;
		doc_bytes.delete();
		add_noise(0, 5);
		if ($urandom_range(99) < 20)
			add_text("xre");
		if ($urandom_range(99) < 8) begin
			add_noise(1, 6);
			return;
		end
		add_text("xref");
		repeat ($urandom_range(3))
			doc_bytes.push_back(lead_set[$urandom_range(2)]);
		for (int s = $urandom_range(1, 3); s > 0; s--) begin
			if ($urandom_range(99) < 10)
				doc_bytes.push_back(8'h41 + 8'($urandom_range(25)));
			r = $urandom_range(99);
			if (r < 6)
				add_number(OBJ_CAP - 64'($urandom_range(3)), 1);
			else if (r < 10)
				add_random_digits(9);
			else
				add_number(64'($urandom_range(999)), 1);
			repeat ($urandom_range(1, 2))
				doc_bytes.push_back(lead_set[$urandom_range(1)]);
			cnt = ($urandom_range(99) < 15) ? 0 : $urandom_range(1, 4);
			add_number(64'(cnt), 1);
			case ($urandom_range(3))
				0: add_text(" ");
				1: add_text("\n");
				2: add_text("\r\n");
				default: add_text(" \r\n");
			endcase
			for (int e = 0; e < cnt; e++) begin
				if ($urandom_range(99) < 10)
					doc_bytes.push_back(ws_set[$urandom_range(5)]);
				r = $urandom_range(99);
				if (r < 8)
					add_random_digits($urandom_range(11, 12));
				else if (r < 14)
					add_random_digits($urandom_range(3));
				else
					add_random_digits(10);
				if ($urandom_range(99) < 2) begin
					cut = 1;
					break;
				end
				add_text(($urandom_range(99) < 90) ? " " : "/");
				r = $urandom_range(99);
				if (r < 8)
					add_random_digits(6);
				else if (r < 16)
					add_text("65535");
				else
					add_number(64'($urandom_range(65535)), 5);
				add_text(($urandom_range(99) < 90) ? " " : "/");
				r = $urandom_range(99);
				if (r < 60)
					doc_bytes.push_back(CH_N);
				else if (r < 95)
					add_text("f");
				else
					doc_bytes.push_back(8'($urandom_range(255)));
				// type letter as the final byte of the document
				if ($urandom_range(99) < 4) begin
					cut = 1;
					break;
				end
				add_text(($urandom_range(1) == 0) ? " \n" : "\r\n");
			end
			if (cut)
				break;
		end
		if (!cut) begin
			if ($urandom_range(99) < 85)
				add_text("trailer");
			add_noise(0, 4);
		end
	endfunction

	task automatic send_byte(logic [7:0] b, logic last);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			stream_if.valid <= 1'b0;
		end
		@(negedge clk);
		stream_if.valid <= 1'b1;
		stream_if.byte_in <= b;
		stream_if.last_byte <= last;
		@(posedge clk);
		while (!stream_if.ready)
			@(posedge clk);
		tracker.take_byte(b, last);
		sent_count++;
	endtask

	task automatic send_document();
		for (int i = 0; i < doc_bytes.size(); i++)
			send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
	endtask

	// stop sending until every expected word is out, then let the pipe settle
	task automatic drain();
		@(negedge clk);
		stream_if.valid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	initial begin
		int phase_end;
		tracker = new();
		sent_count = 0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		stream_if.valid = 1'b0;
		stream_if.byte_in = '0;
		stream_if.last_byte = 1'b0;
		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// one entry with saturated generation, then a document without the keyword
		doc_bytes.delete();
		add_text("xref\r\n9 1\n12 99999 n \nt%");
		send_document();
		doc_bytes.delete();
		add_text("q");
		send_document();
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 74; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 74; end
				default: begin idle_pct = 35; stall_pct = 35; end
			endcase
			phase_end = sent_count + PHASE_BYTES;
			while (sent_count < phase_end) begin
				build_document();
				send_document();
			end
			drain();
		end

		if (tracker.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
